// ===== rtl/core/rdbb_pkg.sv =====
package rdbb_pkg;

    localparam int unsigned CFG_W       = 13;
    localparam int unsigned POS_W       = 12;
    localparam int unsigned MAX_DIM     = 4096;
    localparam int unsigned DISC_RADIUS = 50;
    localparam int unsigned OFS_W       = 6;
    localparam int unsigned SQ_W        = 13;
    localparam int unsigned DIST_W      = 6;
    localparam int unsigned PROD_W      = 14;
    localparam int unsigned RECIP       = 5243;
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned QUOT_W      = PROD_W + RECIP_W;
    localparam int unsigned LANE_LAT    = 3;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix;

    typedef struct packed {
        logic near;
        t_pix pix;
    } t_tag;

endpackage

// ===== rtl/core/rdbb_geom.sv =====
module rdbb_geom
    import rdbb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [CFG_W-1:0]    i_width,
    input  logic [CFG_W-1:0]    i_height,
    input  logic [POS_W-1:0]    i_column,
    input  logic [POS_W-1:0]    i_row,
    input  t_pix                i_pix,
    output logic                o_valid,
    output t_tag                o_tag,
    output logic [SQ_W-1:0]     o_sum
);

    logic [CFG_W-1:0] w_clamp;
    logic [CFG_W-1:0] h_clamp;
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic [POS_W-1:0] adx;
    logic [POS_W-1:0] ady;
    logic             in_frame;
    logic             n_near;

    logic             r_valid1;
    t_tag             r_tag1;
    logic [OFS_W-1:0] r_adx;
    logic [OFS_W-1:0] r_ady;
    logic             r_valid2;
    t_tag             r_tag2;
    logic [SQ_W-1:0]  r_sum;

    always_comb begin
        w_clamp  = (i_width > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : i_width;
        h_clamp  = (i_height > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : i_height;
        cx       = w_clamp[CFG_W-1:1];
        cy       = h_clamp[CFG_W-1:1];
        adx      = (i_column >= cx) ? (i_column - cx) : (cx - i_column);
        ady      = (i_row >= cy) ? (i_row - cy) : (cy - i_row);
        in_frame = ({1'b0, i_column} < w_clamp) && ({1'b0, i_row} < h_clamp);
        n_near   = in_frame && (adx < POS_W'(DISC_RADIUS)) && (ady < POS_W'(DISC_RADIUS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1.near <= n_near;
        r_tag1.pix  <= i_pix;
        r_adx       <= adx[OFS_W-1:0];
        r_ady       <= ady[OFS_W-1:0];
        r_tag2      <= r_tag1;
        r_sum       <= SQ_W'(r_adx * r_adx) + SQ_W'(r_ady * r_ady);
    end

    assign o_valid = r_valid2;
    assign o_tag   = r_tag2;
    assign o_sum   = r_sum;

endmodule

// ===== rtl/core/rdbb_root.sv =====
module rdbb_root
    import rdbb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_tag                i_tag,
    input  logic [SQ_W-1:0]     i_sum,
    output logic                o_valid,
    output t_tag                o_tag,
    output logic [DIST_W-1:0]   o_dist
);

    // one result bit per stage: largest d with d*(d-1) < sum
    logic              r_valid [DIST_W+1];
    t_tag              r_tag   [DIST_W+1];
    logic [SQ_W-1:0]   r_sum   [DIST_W+1];
    logic [DIST_W-1:0] r_dist  [DIST_W+1];

    always_comb begin
        r_valid[0] = i_valid;
        r_tag[0]   = i_tag;
        r_sum[0]   = i_sum;
        r_dist[0]  = '0;
    end

    for (genvar g = 0; g < DIST_W; g++) begin : g_step
        logic [DIST_W-1:0]   trial;
        logic [2*DIST_W-1:0] prod;

        always_comb begin
            trial = r_dist[g] | (DIST_W'(1) << (DIST_W - 1 - g));
            prod  = trial * (trial - DIST_W'(1));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[g+1]  <= r_tag[g];
            r_sum[g+1]  <= r_sum[g];
            r_dist[g+1] <= (SQ_W'(prod) < r_sum[g]) ? trial : r_dist[g];
        end
    end

    assign o_valid = r_valid[DIST_W];
    assign o_tag   = r_tag[DIST_W];
    assign o_dist  = r_dist[DIST_W];

endmodule

// ===== rtl/core/rdbb_lane.sv =====
module rdbb_lane
    import rdbb_pkg::*;
(
    input  logic                i_clk,
    input  logic [7:0]          i_colour,
    input  logic [DIST_W-1:0]   i_gain,
    input  logic                i_boost,
    output logic [7:0]          o_colour
);

    logic [PROD_W-1:0]  r_prod;
    logic [7:0]         r_c1;
    logic               r_en1;
    logic [QUOT_W-1:0]  r_quot;
    logic [7:0]         r_c2;
    logic               r_en2;
    logic [7:0]         r_out;
    logic [8:0]         sum;

    // floor(p / 100) through a scaled reciprocal
    always_comb begin
        sum = {1'b0, r_c2} + 9'(r_quot >> RECIP_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_colour * i_gain);
        r_c1   <= i_colour;
        r_en1  <= i_boost;
        r_quot <= QUOT_W'(r_prod * RECIP_W'(RECIP));
        r_c2   <= r_c1;
        r_en2  <= r_en1;
        if (!r_en2) begin
            r_out <= r_c2;
        end else if (sum[8]) begin
            r_out <= 8'hFF;
        end else begin
            r_out <= sum[7:0];
        end
    end

    assign o_colour = r_out;

endmodule

// ===== rtl/core/radial_disc_brightness_boost.sv =====
// channel   direction  transaction when              payload
// config    in         i_cfg_we high                 i_cfg_idx, i_cfg_data
// pixel     in         start high and busy low       i_column, i_row, i_*_in
// result    out        o_valid high (one cycle)      o_*_out, o_inside_disc
//
// one pixel per clock, each result leaving through the stages below; busy stays low
// the stages are the centre offset and square, a six-stage rounded root search,
// the colour lanes and the output register
// synchronous active-low reset clears the pipeline valid bits and sets the
// frame size to 640 x 480; the receiver cannot stall, so nothing back-pressures
module radial_disc_brightness_boost
    import rdbb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [POS_W-1:0]  i_column,
    input  logic [POS_W-1:0]  i_row,
    input  logic [7:0]        i_red_in,
    input  logic [7:0]        i_green_in,
    input  logic [7:0]        i_blue_in,
    input  logic [7:0]        i_alpha_in,
    output logic              o_valid,
    output logic [7:0]        o_red_out,
    output logic [7:0]        o_green_out,
    output logic [7:0]        o_blue_out,
    output logic [7:0]        o_alpha_out,
    output logic              o_inside_disc
);

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;

    t_pix              in_pix;
    logic              geo_valid;
    t_tag              geo_tag;
    logic [SQ_W-1:0]   geo_sum;
    logic              root_valid;
    t_tag              root_tag;
    logic [DIST_W-1:0] root_dist;
    logic              boost_en;
    logic [DIST_W-1:0] gain;
    logic [7:0]        lane_red;
    logic [7:0]        lane_green;
    logic [7:0]        lane_blue;

    logic              r_dvalid  [LANE_LAT];
    logic              r_dinside [LANE_LAT];
    logic [7:0]        r_dalpha  [LANE_LAT];

    logic              r_valid;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;
    logic [7:0]        r_alpha;
    logic              r_inside;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
        end else if (i_cfg_we && (i_cfg_idx[1] == 1'b0)) begin
            unique case (i_cfg_idx[0])
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    assign in_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in, alpha: i_alpha_in};

    rdbb_geom u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_width  (r_frame_width),
        .i_height (r_frame_height),
        .i_column (i_column),
        .i_row    (i_row),
        .i_pix    (in_pix),
        .o_valid  (geo_valid),
        .o_tag    (geo_tag),
        .o_sum    (geo_sum)
    );

    rdbb_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geo_valid),
        .i_tag   (geo_tag),
        .i_sum   (geo_sum),
        .o_valid (root_valid),
        .o_tag   (root_tag),
        .o_dist  (root_dist)
    );

    assign boost_en = root_tag.near && (root_dist < DIST_W'(DISC_RADIUS));
    assign gain     = DIST_W'(DISC_RADIUS) - root_dist;

    rdbb_lane u_lane_red (
        .i_clk    (i_clk),
        .i_colour (root_tag.pix.red),
        .i_gain   (gain),
        .i_boost  (boost_en),
        .o_colour (lane_red)
    );

    rdbb_lane u_lane_green (
        .i_clk    (i_clk),
        .i_colour (root_tag.pix.green),
        .i_gain   (gain),
        .i_boost  (boost_en),
        .o_colour (lane_green)
    );

    rdbb_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_colour (root_tag.pix.blue),
        .i_gain   (gain),
        .i_boost  (boost_en),
        .o_colour (lane_blue)
    );

    // side band kept level with the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_dvalid[k] <= 1'b0;
            end
            r_valid <= 1'b0;
        end else begin
            r_dvalid[0] <= root_valid;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_dvalid[k] <= r_dvalid[k-1];
            end
            r_valid <= r_dvalid[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dinside[0] <= boost_en;
        r_dalpha[0]  <= root_tag.pix.alpha;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_dinside[k] <= r_dinside[k-1];
            r_dalpha[k]  <= r_dalpha[k-1];
        end
        r_red    <= lane_red;
        r_green  <= lane_green;
        r_blue   <= lane_blue;
        r_alpha  <= r_dalpha[LANE_LAT-1];
        r_inside <= r_dinside[LANE_LAT-1];
    end

    assign o_valid       = r_valid;
    assign o_red_out     = r_red;
    assign o_green_out   = r_green;
    assign o_blue_out    = r_blue;
    assign o_alpha_out   = r_alpha;
    assign o_inside_disc = r_inside;

endmodule
